### hw/rtl/rcw_pkg.sv
// ----------------------------------------------------------------------------
// rcw_pkg: shared types and constants of the reorder commit window
// Holds the transaction structs, the result kinds and the window sizing.
// ----------------------------------------------------------------------------
package rcw_pkg;

	localparam int WINDOW = 32;
	localparam int SLOT_W = $clog2(WINDOW);

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		KIND_RETIRED = 2'd0,
		KIND_NOPROG  = 2'd1,
		KIND_REJECT  = 2'd2
	} kind_t;

	typedef struct packed {
		logic [31:0] frame_seq;
		logic        is_match;
	} in_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] out_seq;
		logic        out_match;
		logic [31:0] match_total;
		logic [31:0] committed_head;
		logic        last;
	} out_t;

	// Head of the input queue as seen by the back end.
	typedef struct packed {
		logic valid;
		in_t  item;
	} rcw_q_t;

endpackage

### hw/rtl/reorder_commit_window.sv
// ----------------------------------------------------------------------------
// reorder_commit_window: in-order commit of out-of-order filter results
// Holds per-frame results in a window past the committed head and retires
// them strictly in sequence order, with a running count of matched frames.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake                   | payload
//   ---------+-----------+-----------------------------+-----------------------
//   item     | in        | item_valid / item_stall     | frame_seq, is_match
//   result   | out       | result_valid / result_stall | kind .. last
//
// A transaction that is rejected or makes no progress is answered by the back
// end as it leaves the queue; one that completes a run is inserted and then
// retires its entries one by one, a run holding up to 32 entries. A single
// shared retire step serves the whole window, and the back end takes no new
// transaction from the queue until the run is through.
// Reset (arst_n low) empties the queue and the window and clears the head and
// the match count at once; no clearing pass follows.
// The input side takes new transactions while the two-entry queue has room,
// even while a result waits on a stalled output register.
//
module reorder_commit_window import rcw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_stall,
	input  in_t  item,
	output logic result_valid,
	input  logic result_stall,
	output out_t result
);

	// The queue head travels to the back end as one struct; the back end
	// pops it as it classifies the transaction and, unless rejected, inserts it.
	rcw_q_t q;
	logic   q_pop;

	// Front end: accepts input transactions and buffers them.
	rcw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.q          (q),
		.q_pop      (q_pop)
	);

	// Back end: owns the window, the head and the match count, and drives
	// the registered result port.
	rcw_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q            (q),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

### hw/rtl/rcw_front.sv
// ----------------------------------------------------------------------------
// rcw_front: input side of the reorder commit window
// Accepts input transactions into a short queue that decouples the window.
// ----------------------------------------------------------------------------
module rcw_front import rcw_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   item_valid,
	output logic   item_stall,
	input  in_t    item,
	output rcw_q_t q,
	input  logic   q_pop
);

	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	in_t               buf_q [QDEPTH];
	logic              push;
	logic              pop;

	assign item_stall = (count_q == QCNT_W'(QDEPTH));
	assign push       = item_valid && !item_stall;
	assign q.valid    = (count_q != '0);
	assign q.item     = buf_q[rd_ptr_q];
	assign pop        = q_pop && q.valid;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		logic [QPTR_W-1:0] n;
		if (p == QPTR_W'(QDEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + QPTR_W'(1);
		end
		return n;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

### hw/rtl/rcw_back.sv
// ----------------------------------------------------------------------------
// rcw_back: window and in-order retire engine
// Classifies each queued transaction against the head, inserts the accepted
// ones into the window, retires the unbroken run one entry per unstalled cycle.
// ----------------------------------------------------------------------------
module rcw_back import rcw_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  rcw_q_t q,
	output logic   q_pop,
	output logic   result_valid,
	input  logic   result_stall,
	output out_t   result
);

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_DRAIN = 2'b10
	} state_t;

	state_t            state_q;
	state_t            state_d;
	logic [WINDOW-1:0] valid_q;
	logic [WINDOW-1:0] match_q;
	logic [31:0]       head_q;
	logic [31:0]       count_q;
	logic              res_valid_q;
	out_t              res_q;

	logic              out_free;
	logic [31:0]       seq_gap;
	logic [31:0]       seq_gap_m1;
	logic [SLOT_W-1:0] idx;
	logic              reject;
	logic              do_insert;
	logic              new_v0;
	logic              retire;
	logic              run_last;
	logic [31:0]       head_inc;
	logic [31:0]       count_inc;
	logic              load;
	out_t              res_d;

	assign out_free     = !res_valid_q || !result_stall;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	assign seq_gap    = q.item.frame_seq - head_q;
	assign seq_gap_m1 = seq_gap - 32'd1;
	assign idx        = seq_gap_m1[SLOT_W-1:0];
	assign reject     = (seq_gap == 32'd0) || (seq_gap > 32'(WINDOW));
	assign new_v0     = valid_q[0] || (idx == '0);

	assign q_pop     = (state_q == ST_IDLE) && q.valid && out_free;
	assign do_insert = q_pop && !reject;
	assign retire    = (state_q == ST_DRAIN) && out_free;
	assign run_last  = !valid_q[1];
	assign head_inc  = head_q + 32'd1;
	assign count_inc = count_q + {31'd0, match_q[0]};

	always_comb begin
		state_d = state_q;
		load    = 1'b0;
		res_d   = res_q;
		unique case (state_q)
			ST_IDLE: begin
				if (q_pop) begin
					if (reject) begin
						load  = 1'b1;
						res_d = '{KIND_REJECT, q.item.frame_seq, 1'b0, count_q, head_q, 1'b1};
					end else if (new_v0) begin
						state_d = ST_DRAIN;
					end else begin
						load  = 1'b1;
						res_d = '{KIND_NOPROG, q.item.frame_seq, 1'b0, count_q, head_q, 1'b1};
					end
				end
			end
			ST_DRAIN: begin
				if (retire) begin
					load  = 1'b1;
					res_d = '{KIND_RETIRED, head_inc, match_q[0], count_inc, head_inc, run_last};
					if (run_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (out_free && load) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			match_q     <= '0;
			head_q      <= '0;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_free) begin
				res_valid_q <= load;
			end
			if (do_insert && !valid_q[idx]) begin
				valid_q[idx] <= 1'b1;
				match_q[idx] <= q.item.is_match;
			end
			if (retire) begin
				valid_q <= {1'b0, valid_q[WINDOW-1:1]};
				match_q <= {1'b0, match_q[WINDOW-1:1]};
				head_q  <= head_inc;
				count_q <= count_inc;
			end
		end
	end

endmodule

### hw/rtl/rcw_checker.sv
// ----------------------------------------------------------------------------
// rcw_checker: port-level checks of the reorder commit window
// Watches the result channel over time and is bound to the top level.
// ----------------------------------------------------------------------------
module rcw_checker import rcw_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic result_valid,
	input logic result_stall,
	input out_t result
);

	logic res_acc;
	assign res_acc = result_valid && !result_stall;

	// A stalled result stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload.
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result))
		else $error("result payload changed while stalled");

	// Within a run, the next retired entry follows in the next cycle, one
	// sequence number higher.
	a_run_seq: assert property (@(posedge clk) disable iff (!arst_n)
		res_acc && (result.kind == KIND_RETIRED) && !result.last |=>
		result_valid && (result.kind == KIND_RETIRED) &&
		(result.committed_head == $past(result.committed_head) + 32'd1))
		else $error("retire run broken");

	// Within a run, the match total grows by exactly the entry's match flag.
	a_run_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_acc && (result.kind == KIND_RETIRED) && !result.last |=>
		(result.match_total == $past(result.match_total) + {31'd0, result.out_match}))
		else $error("match total out of step");

endmodule

bind reorder_commit_window rcw_checker u_rcw_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

### verif/reorder_commit_window_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// reorder_commit_window_tb: self-checking testbench of the reorder commit window
// Sends out-of-order frame results through the item channel and checks every
// result transaction against a behavioral model of the window kept here.
// ----------------------------------------------------------------------------
module reorder_commit_window_tb;
	import rcw_pkg::*;

	// A hold-off long enough that the input queue and the output register are
	// certain to fill, so the block has to stall its item channel.
	localparam int HOLD_CYCLES = 300;
	// The slowest transaction is inserted and then retires a full window of entries.
	localparam int TAIL_CYCLES = 2 * WINDOW + 8;
	localparam int LIMIT_NS = 4_000_000;
	localparam int DIR_ROWS = 22;

	// One row of the directed part. Where typed is set, the row's own
	// expectation is queued instead of the model's: those rows give exactly one
	// result, with out_match low and last high.
	typedef struct packed {
		logic [31:0] seq;
		logic        m;
		logic        typed;
		kind_t       k;
		logic [31:0] mt;
		logic [31:0] hd;
	} stim_row_t;

	// The directed walk starts from reset: head 0, no matches. Along the way
	// it hits the window edge, the frame at the head, frames far outside the
	// window, duplicates, gaps and short runs that close those gaps.
	localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
		'{32'h0000_0000, 1'b1, 1'b1, KIND_REJECT, 32'd0, 32'd0},
		'{32'h0000_0021, 1'b1, 1'b1, KIND_REJECT, 32'd0, 32'd0},
		'{32'hFFFF_FFFF, 1'b0, 1'b1, KIND_REJECT, 32'd0, 32'd0},
		'{32'h8000_0000, 1'b1, 1'b1, KIND_REJECT, 32'd0, 32'd0},
		'{32'h0000_0020, 1'b1, 1'b1, KIND_NOPROG, 32'd0, 32'd0},
		'{32'h0000_0020, 1'b0, 1'b1, KIND_NOPROG, 32'd0, 32'd0},
		'{32'h0000_0003, 1'b1, 1'b1, KIND_NOPROG, 32'd0, 32'd0},
		'{32'h0000_0002, 1'b0, 1'b1, KIND_NOPROG, 32'd0, 32'd0},
		'{32'h0000_0001, 1'b1, 1'b0, KIND_RETIRED, 32'd0, 32'd0},
		'{32'h0000_0003, 1'b0, 1'b1, KIND_REJECT, 32'd2, 32'd3},
		'{32'h0000_0002, 1'b1, 1'b1, KIND_REJECT, 32'd2, 32'd3},
		'{32'h0000_0024, 1'b0, 1'b1, KIND_REJECT, 32'd2, 32'd3},
		'{32'h0000_0023, 1'b1, 1'b1, KIND_NOPROG, 32'd2, 32'd3},
		'{32'h0000_0005, 1'b1, 1'b1, KIND_NOPROG, 32'd2, 32'd3},
		'{32'h0000_0005, 1'b0, 1'b1, KIND_NOPROG, 32'd2, 32'd3},
		'{32'h0000_0004, 1'b0, 1'b0, KIND_RETIRED, 32'd0, 32'd0},
		'{32'h0000_0006, 1'b1, 1'b0, KIND_RETIRED, 32'd0, 32'd0},
		'{32'h0000_0007, 1'b0, 1'b0, KIND_RETIRED, 32'd0, 32'd0},
		'{32'h7FFF_FFFF, 1'b0, 1'b1, KIND_REJECT, 32'd4, 32'd7},
		'{32'hAAAA_AAAA, 1'b1, 1'b1, KIND_REJECT, 32'd4, 32'd7},
		'{32'h5555_5555, 1'b0, 1'b1, KIND_REJECT, 32'd4, 32'd7},
		'{32'h0000_0008, 1'b1, 1'b0, KIND_RETIRED, 32'd0, 32'd0}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	in_t  item;
	logic result_valid;
	logic result_stall;
	out_t result;

	// Shadow copy of the window and the commit state.
	logic        win_valid [WINDOW];
	logic        win_match [WINDOW];
	logic [31:0] pred_head;
	logic [31:0] pred_matches;

	// Results still owed by the block, oldest first.
	out_t due_results [$];

	// Idling control shared by the two sides.
	logic quiet;
	logic hold_req;

	int fail_count;
	int frames_sent;
	int frames_rejected;
	int frames_noprog;
	int entries_retired;
	int longest_run;
	int results_checked;
	int input_stall_cycles;

	reorder_commit_window DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #2 clk = ~clk;

	// Run one accepted frame through the shadow window. The state always
	// advances; the results are queued only when keep is set, so a typed row
	// can stand in for them.
	function automatic void predict_commit(in_t frame, bit keep);
		logic [31:0] gap;
		int          run;
		out_t        r;

		gap = frame.frame_seq - pred_head;
		r = '0;
		r.out_seq = frame.frame_seq;
		r.last = 1'b1;

		// A distance of zero is the head itself; the modulo distance also
		// folds every number below the head into a huge value.
		if (gap == 32'd0 || gap > WINDOW) begin
			frames_rejected++;
			r.kind = KIND_REJECT;
			r.match_total = pred_matches;
			r.committed_head = pred_head;
			if (keep)
				due_results = {due_results, r};
			return;
		end

		// A duplicate never overwrites the flag of the first arrival.
		if (!win_valid[gap - 1]) begin
			win_valid[gap - 1] = 1'b1;
			win_match[gap - 1] = frame.is_match;
		end

		run = 0;
		while (run < WINDOW && win_valid[run])
			run++;

		if (run == 0) begin
			frames_noprog++;
			r.kind = KIND_NOPROG;
			r.match_total = pred_matches;
			r.committed_head = pred_head;
			if (keep)
				due_results = {due_results, r};
			return;
		end

		for (int k = 0; k < run; k++) begin
			pred_head = pred_head + 32'd1;
			if (win_match[k])
				pred_matches = pred_matches + 32'd1;
			r.kind = KIND_RETIRED;
			r.out_seq = pred_head;
			r.out_match = win_match[k];
			r.match_total = pred_matches;
			r.committed_head = pred_head;
			r.last = (k == run - 1);
			if (keep)
				due_results = {due_results, r};
		end
		entries_retired += run;
		if (run > longest_run)
			longest_run = run;

		// Every retired slot is freed as the window slides down.
		for (int k = 0; k < WINDOW; k++) begin
			if (k + run < WINDOW) begin
				win_valid[k] = win_valid[k + run];
				win_match[k] = win_match[k + run];
			end else begin
				win_valid[k] = 1'b0;
				win_match[k] = 1'b0;
			end
		end
	endfunction

	// Offer one frame and wait until the block takes it. The task is entered at
	// a falling edge and returns at the falling edge after acceptance, with
	// valid still high, so back-to-back frames need no bubble. Whoever waits
	// afterwards for any other reason lowers valid first.
	task automatic send_frame(in_t frame, bit typed, out_t typed_result);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			item_valid = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		item = frame;
		item_valid = 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		frames_sent++;
		predict_commit(frame, !typed);
		if (typed)
			due_results = {due_results, typed_result};
		@(negedge clk);
	endtask

	task automatic wait_drained();
		item_valid = 1'b0;
		while (due_results.size() != 0)
			@(negedge clk);
	endtask

	// Random traffic until at least the given number of frames is sent. Most of
	// it is runs of consecutive numbers from head + 1, in shuffled order, so
	// that gaps open and close and runs retire. Some runs leave out their first
	// frame and stay parked in the window; some frames are sent twice with the
	// flag flipped. The rest probes the window edges and the full number space.
	task automatic random_phase(int goal);
		int          offs [WINDOW];
		int          len;
		int          pick;
		int          j;
		int          tmp;
		logic [31:0] base;
		bit          broken;
		in_t         frame;

		while (frames_sent < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				len = ($urandom_range(0, 9) == 0) ? WINDOW : $urandom_range(1, 8);
				base = pred_head;
				broken = ($urandom_range(0, 6) == 0);
				for (int i = 0; i < len; i++)
					offs[i] = i + 1;
				for (int i = len - 1; i > 0; i--) begin
					j = $urandom_range(0, i);
					tmp = offs[i];
					offs[i] = offs[j];
					offs[j] = tmp;
				end
				for (int i = 0; i < len; i++) begin
					if (!(broken && offs[i] == 1)) begin
						frame.frame_seq = base + offs[i];
						frame.is_match = 1'($urandom_range(0, 1));
						send_frame(frame, 1'b0, '0);
						if ($urandom_range(0, 9) == 0) begin
							frame.is_match = ~frame.is_match;
							send_frame(frame, 1'b0, '0);
						end
					end
				end
			end else if (pick < 85) begin
				// From the head itself to just past the far edge of the window.
				frame.frame_seq = pred_head + $urandom_range(0, WINDOW + 2);
				frame.is_match = 1'($urandom_range(0, 1));
				send_frame(frame, 1'b0, '0);
			end else begin
				frame.frame_seq = $urandom;
				frame.is_match = 1'($urandom_range(0, 1));
				send_frame(frame, 1'b0, '0);
			end
		end
	endtask

	// Result side: random stall bursts, or one long hold-off when asked for.
	// The hold-off is counted here so the sender keeps offering frames meanwhile.
	initial begin
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				result_stall = 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				result_stall = 1'b1;
				repeat ($urandom_range(1, 8) - 1) @(negedge clk);
			end else begin
				result_stall = 1'b0;
			end
		end
	end

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			fail_count++;
			$display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	// Every result transaction is matched against the oldest expectation.
	always @(posedge clk) begin
		out_t want;

		if (arst_n) begin
			if (item_valid && item_stall)
				input_stall_cycles++;
			if (result_valid && !result_stall) begin
				if (due_results.size() == 0) begin
					fail_count++;
					$display("%0t ns: result with none expected, expected nothing, actual %h",
						$time, result);
				end else begin
					want = due_results.pop_front();
					results_checked++;
					check_field("kind", 32'(want.kind), 32'(result.kind));
					check_field("out_seq", want.out_seq, result.out_seq);
					check_field("out_match", 32'(want.out_match), 32'(result.out_match));
					check_field("match_total", want.match_total, result.match_total);
					check_field("committed_head", want.committed_head,
						result.committed_head);
					check_field("last", 32'(want.last), 32'(result.last));
				end
			end
		end
	end

	initial begin
		#(LIMIT_NS);
		$display("%0t ns: run did not finish in time, %0d results outstanding",
			$time, due_results.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		in_t  frame;
		out_t typed_result;

		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		quiet = 1'b0;
		hold_req = 1'b0;
		fail_count = 0;
		frames_sent = 0;
		frames_rejected = 0;
		frames_noprog = 0;
		entries_retired = 0;
		longest_run = 0;
		results_checked = 0;
		input_stall_cycles = 0;
		pred_head = '0;
		pred_matches = '0;
		for (int i = 0; i < WINDOW; i++) begin
			win_valid[i] = 1'b0;
			win_match[i] = 1'b0;
		end

		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part: walk the table.
		for (int i = 0; i < DIR_ROWS; i++) begin
			frame.frame_seq = DIR_TABLE[i].seq;
			frame.is_match = DIR_TABLE[i].m;
			typed_result = '0;
			typed_result.kind = DIR_TABLE[i].k;
			typed_result.out_seq = DIR_TABLE[i].seq;
			typed_result.match_total = DIR_TABLE[i].mt;
			typed_result.committed_head = DIR_TABLE[i].hd;
			typed_result.last = 1'b1;
			send_frame(frame, DIR_TABLE[i].typed, typed_result);
		end

		// The sender pauses here until the block owes nothing.
		wait_drained();

		random_phase(DIR_ROWS + 180);

		// Long hold-off on the result side while frames keep coming, so the
		// queue fills and the item channel backs up.
		hold_req = 1'b1;
		random_phase(DIR_ROWS + 340);
		wait_drained();

		// Last stretch at full rate on both sides.
		quiet = 1'b1;
		random_phase(420);

		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Sent %0d frames: %0d rejected, %0d without progress; checked %0d results.",
			frames_sent, frames_rejected, frames_noprog, results_checked);
		$display("Retired %0d entries, longest run %0d, item channel stalled %0d cycles.",
			entries_retired, longest_run, input_stall_cycles);
		if (fail_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
